/* src/dps_pkg.sv */
// Package for the password substitute unit: DES tables, permutation
// functions and the pipeline stage type. Depends on nothing.
package dps_pkg;

    localparam int NumRounds = 16;
    localparam int NumDes    = 6;
    localparam int NumStages = NumRounds * NumDes;

    localparam logic [6:0] IP_TAB [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [6:0] FP_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [5:0] E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam logic [5:0] P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam logic [6:0] PC1_TAB [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam logic [5:0] PC2_TAB [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam logic [1:0] ROT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] SBOX [8][64] = '{
     '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
       4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
     '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
       0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
     '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
       13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
     '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
       10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
     '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
       4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
     '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
       9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
     '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
       1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
     '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
       7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // State carried by one pipeline stage.
    typedef struct packed {
        logic [31:0] l;
        logic [31:0] r;
        logic [27:0] c;
        logic [27:0] d;
        logic [63:0] seq;
        logic [63:0] cseed;
        logic [63:0] uid1;
        logic [63:0] uid2;
    } stage_t;

    // Table permutations; position 1 is the most significant bit.
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] res;
        for (int i = 0; i < 64; i++) res[63-i] = v[64-int'(IP_TAB[i])];
        return res;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] res;
        for (int i = 0; i < 64; i++) res[63-i] = v[64-int'(FP_TAB[i])];
        return res;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] res;
        for (int i = 0; i < 56; i++) res[55-i] = v[64-int'(PC1_TAB[i])];
        return res;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] res;
        for (int i = 0; i < 48; i++) res[47-i] = v[56-int'(PC2_TAB[i])];
        return res;
    endfunction

    // Cipher function: expansion, key mix, S-boxes and P permutation.
    function automatic logic [31:0] des_f(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] res;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(E_TAB[i])];
        e = e ^ k;
        for (int j = 0; j < 8; j++)
        begin
            six = e[47-6*j -: 6];
            s[31-4*j -: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) res[31-i] = s[32-int'(P_TAB[i])];
        return res;
    endfunction

    // Left rotation of a 28-bit key half by one or two places.
    function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] k);
        return (k == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
    endfunction

endpackage

/* src/des_password_substitute_unit.sv */
// Top level of the password substitute unit: a 96-stage DES round pipeline.
// Depends on dps_pkg.
//
// One transaction enters per clock while the pipeline is not held, and its
// substitute is offered once it has passed an input stage (key preparation,
// seed increment) followed by one register stage per DES round, six
// encryptions of sixteen rounds each; the last round register is the output
// register. The pipeline holds as a whole while a finished result is not
// taken, and then accepts nothing.
module des_password_substitute_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0 up: password_block, user_id_first, user_id_second,
    // server_seed, client_seed.
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0 up: substitute.
    output logic [63:0]  m_tdata
);
    import dps_pkg::*;

    stage_t st_reg [NumStages+1];
    stage_t st_next [NumStages+1];
    logic   vld_reg [NumStages+1];
    logic   en;

    assign en       = !vld_reg[NumStages] || m_tready;
    assign s_tready = en;

    // Input stage: derive the key, apply IP to the first user id half.
    always_comb
    begin
        logic [63:0] key;
        logic [55:0] cd;
        logic [63:0] x;
        key = (s_tdata[63:0] ^ 64'h5555555555555555) << 1;
        cd  = perm_pc1(key);
        x   = perm_ip(s_tdata[127:64]);
        st_next[0].l     = x[63:32];
        st_next[0].r     = x[31:0];
        st_next[0].c     = cd[55:28];
        st_next[0].d     = cd[27:0];
        st_next[0].seq   = s_tdata[255:192] + 64'd1;
        st_next[0].cseed = s_tdata[319:256];
        st_next[0].uid1  = s_tdata[127:64];
        st_next[0].uid2  = s_tdata[191:128];
    end

    // Round stages; a stage that opens a new encryption first closes the
    // previous one and builds the next CBC input block.
    for (genvar k = 0; k < NumStages; k++)
    begin : g_round
        localparam int Rnd = k % NumRounds;
        localparam int Enc = k / NumRounds;
        always_comb
        begin
            stage_t      cur;
            logic [63:0] ct;
            logic [63:0] blk;
            logic [63:0] x;
            logic [55:0] cd;
            logic [31:0] f;
            cur = st_reg[k];
            ct  = perm_fp({cur.r, cur.l});
            blk = 64'd0;
            x   = 64'd0;
            cd  = 56'd0;
            if (Rnd == 0 && Enc > 0)
            begin
                case (Enc)
                    1: blk = cur.seq;
                    2: blk = cur.cseed ^ ct;
                    3: blk = cur.uid1 ^ cur.seq ^ ct;
                    4: blk = cur.uid2 ^ cur.seq ^ ct;
                    default: blk = 64'd1 ^ ct;
                endcase
                x = perm_ip(blk);
                cur.l = x[63:32];
                cur.r = x[31:0];
                // The token becomes the key; later encryptions reuse it, and
                // sixteen rotations bring the key halves back to their start.
                if (Enc == 1)
                begin
                    cd = perm_pc1(ct);
                    cur.c = cd[55:28];
                    cur.d = cd[27:0];
                end
            end
            cur.c = rot28(cur.c, ROT_TAB[Rnd]);
            cur.d = rot28(cur.d, ROT_TAB[Rnd]);
            f = des_f(cur.r, perm_pc2({cur.c, cur.d}));
            st_next[k+1]   = cur;
            st_next[k+1].l = cur.r;
            st_next[k+1].r = cur.l ^ f;
        end
    end

    // Stage registers; valid bits are reset, payload is not.
    for (genvar k = 0; k <= NumStages; k++)
    begin : g_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // Final ciphertext: undo the last swap and apply FP.
    assign m_tvalid = vld_reg[NumStages];
    assign m_tdata  = perm_fp({st_reg[NumStages].r, st_reg[NumStages].l});

endmodule

/* dv/des_password_substitute_unit_tb.sv */
// Self-checking testbench for des_password_substitute_unit: drives password
// substitute requests, predicts each substitute with its own DES model and
// compares. Depends on dps_pkg (table constants) and the unit's RTL.
module des_password_substitute_unit_tb;
    import dps_pkg::*;

    localparam int RandomRequests = 730;
    localparam int IdleLimit      = 4000;
    localparam int DrainCycles    = 120;

    typedef struct {
        logic [63:0] password;
        logic [63:0] uid_first;
        logic [63:0] uid_second;
        logic [63:0] server_seed;
        logic [63:0] client_seed;
        logic        known;
        logic [63:0] known_sub;
    } request_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;

    logic [63:0] pending_subs [$];
    request_t    directed_reqs [$];
    int          error_count;
    int          idle_cycles;
    int          results_seen;
    bit          stimulus_done;

    des_password_substitute_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Plain DES block encryption, positions counted from the most significant bit.
    function automatic logic [63:0] des_block(input logic [63:0] key, input logic [63:0] blk);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [47:0] subkey [16];
        logic [47:0] ex;
        logic [63:0] x;
        logic [63:0] y;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] sout;
        logic [31:0] f;
        logic [31:0] t;
        logic [55:0] joined;
        logic [5:0]  six;
        int          sh;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(PC1_TAB[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++)
        begin
            sh = int'(ROT_TAB[i]);
            c = (c << sh) | (c >> (28 - sh));
            d = (d << sh) | (d >> (28 - sh));
            joined = {c, d};
            for (int j = 0; j < 48; j++) subkey[i][47-j] = joined[56-int'(PC2_TAB[j])];
        end
        for (int i = 0; i < 64; i++) x[63-i] = blk[64-int'(IP_TAB[i])];
        l = x[63:32];
        r = x[31:0];
        for (int i = 0; i < 16; i++)
        begin
            for (int j = 0; j < 48; j++) ex[47-j] = r[32-int'(E_TAB[j])];
            ex = ex ^ subkey[i];
            for (int s = 0; s < 8; s++)
            begin
                six = ex[47-6*s -: 6];
                sout[31-4*s -: 4] = SBOX[s][{six[5], six[0], six[4:1]}];
            end
            for (int j = 0; j < 32; j++) f[31-j] = sout[32-int'(P_TAB[j])];
            t = r;
            r = l ^ f;
            l = t;
        end
        x = {r, l};
        for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(FP_TAB[i])];
        return y;
    endfunction

    // Password substitute: token from the masked password, then five CBC blocks.
    function automatic logic [63:0] predict_substitute(input request_t q);
        logic [63:0] pw_key;
        logic [63:0] token;
        logic [63:0] seq;
        logic [63:0] chain;
        logic [63:0] blocks [5];
        pw_key = (q.password ^ 64'h5555_5555_5555_5555) << 1;
        token  = des_block(pw_key, q.uid_first);
        seq    = q.server_seed + 64'd1;
        blocks[0] = seq;
        blocks[1] = q.client_seed;
        blocks[2] = q.uid_first ^ seq;
        blocks[3] = q.uid_second ^ seq;
        blocks[4] = 64'd1;
        chain = '0;
        for (int i = 0; i < 5; i++) chain = des_block(token, blocks[i] ^ chain);
        return chain;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Blank-padded EBCDIC-like text: random uppercase letters then blanks.
    function automatic logic [63:0] rand_text();
        logic [63:0] v;
        int          n;
        n = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++)
            v[63-8*i -: 8] = (i < n) ? 8'(8'hC1 + $urandom_range(0, 8)) : 8'h40;
        return v;
    endfunction

    function automatic request_t make_req(input logic [63:0] pw, input logic [63:0] u1,
                                          input logic [63:0] u2, input logic [63:0] ss,
                                          input logic [63:0] cs);
        request_t q;
        q.password    = pw;
        q.uid_first   = u1;
        q.uid_second  = u2;
        q.server_seed = ss;
        q.client_seed = cs;
        q.known       = 1'b0;
        q.known_sub   = '0;
        return q;
    endfunction

    // Send one request transaction after a random gap.
    task automatic send_request(input request_t q);
        int gap;
        gap = $urandom_range(0, 5);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {q.client_seed, q.server_seed, q.uid_second, q.uid_first, q.password};
        pending_subs = {pending_subs, (q.known ? q.known_sub : predict_substitute(q))};
        do @(posedge clk); while (!s_tready);
    endtask

    // Directed rows: extremes, key parity, seed wrap, realistic text.
    initial
    begin
        directed_reqs = {directed_reqs, make_req('0, '0, '0, '0, '0)};
        directed_reqs = {directed_reqs, make_req('1, '1, '1, '1, '1)};
        directed_reqs = {directed_reqs, make_req(64'hAAAA_AAAA_AAAA_AAAA, '0, '1, 64'h1, '0)};
        // Seed wrap: all ones becomes zero.
        directed_reqs = {directed_reqs, make_req(64'hC1C2C3C4_40404040, 64'hD4E8E2C5_D9404040,
                                         64'h40404040_40404040, '1, 64'h0123_4567_89AB_CDEF)};
        // Key parity: flipping the bits that land on the key bytes' low bits or shift out.
        directed_reqs = {directed_reqs, make_req(64'hC1C2C3C4_40404040, 64'hD4E8E2C5_D9404040,
                                         64'h40404040_40404040, 64'h1122_3344_5566_7788, '0)};
        directed_reqs = {directed_reqs,
                         make_req(64'hC1C2C3C4_40404040 ^ 64'h8080_8080_8080_8080,
                                  64'hD4E8E2C5_D9404040, 64'h40404040_40404040,
                                  64'h1122_3344_5566_7788, '0)};
        directed_reqs = {directed_reqs,
                         make_req(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                                  64'h1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000)};
        directed_reqs = {directed_reqs, make_req(64'h1, 64'h1, 64'h8000_0000_0000_0000,
                                         64'hFFFF_FFFF_FFFF_FFFE, '1)};
        for (int i = 0; i < 8; i++)
            directed_reqs = {directed_reqs, make_req(rand_text(), rand_text(), rand_text(),
                                                     rand64(), rand64())};
    end

    // Stimulus.
    initial
    begin
        request_t q;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        stimulus_done = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed_reqs[i]) send_request(directed_reqs[i]);
        for (int i = 0; i < RandomRequests; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                q = make_req(rand64(), rand64(), rand64(), rand64(), rand64());
            else
                q = make_req(rand_text(), rand_text(), rand_text(), rand64(), rand64());
            if ($urandom_range(0, 15) == 0) q.server_seed = '1;
            send_request(q);
            // Hold off once mid-run until every result has drained.
            if (i == RandomRequests / 2)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                wait (pending_subs.size() == 0);
            end
        end
        @(negedge clk);
        s_tvalid      <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Result ready: random stalls, with stretches of steady acceptance.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            @(negedge clk);
            m_tready <= (stall == 0);
            if (stall != 0)
            begin
                repeat (stall - 1) @(negedge clk);
                @(negedge clk);
                m_tready <= 1'b1;
            end
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Result checking and watchdog.
    initial
    begin
        logic [63:0] want;
        error_count  = 0;
        idle_cycles  = 0;
        results_seen = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_subs.size() == 0)
                begin
                    $error("substitute: unexpected transaction, actual %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_subs.pop_front();
                    results_seen++;
                    if (m_tdata !== want)
                    begin
                        $error("substitute: expected %h actual %h", want, m_tdata);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= IdleLimit)
            begin
                $display("Timeout with %0d results outstanding", pending_subs.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // End of run.
    initial
    begin
        wait (stimulus_done);
        wait (pending_subs.size() == 0);
        repeat (DrainCycles) @(posedge clk);
        $display("Checked %0d substitutes from directed and random requests,", results_seen);
        $display("including seed wrap, key parity bits and output stalls.");
        if (error_count == 0 && pending_subs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
